// ===== rtl/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants for the call log table
// Field widths, operation codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clm_pkg;

   localparam int LOG_DEPTH_DEF = 32;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int KIND_W  = 2;
   localparam int DUR_W   = 32;
   localparam int IDX_W   = 5;
   localparam int COUNT_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_PATCH = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHF_RD,
      ST_SHF_WR,
      ST_APPEND,
      ST_PATCH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_NEXT,
      RD_ENTRY
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_APPEND,
      WR_PATCH
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      PEND_HOLD,
      PEND_CLR,
      PEND_APPEND
   } pend_op_type;

   typedef enum logic [1:0] {
      SCAN_HOLD,
      SCAN_CLR,
      SCAN_INC
   } scan_op_type;

   typedef struct packed {
      logic        load_req;
      logic        rd_en;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      cnt_op_type  cnt_op;
      pend_op_type pend_op;
      scan_op_type scan_op;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   key_match;
      logic   scan_last;
      logic   count_zero;
      logic   count_full;
      logic   read_hit;
      logic   patch_ok;
      logic   rsp_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/clm_ctrl.sv =====
// ----------------------------------------------------------------------------
// clm_ctrl: sequencer for the call log table
// Takes one request at a time, walks the store for search and compaction,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clm_ctrl
   import clm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd.load_req = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.rd_sel   = RD_SCAN;
      cmd.wr_sel   = WR_NONE;
      cmd.cnt_op   = CNT_HOLD;
      cmd.pend_op  = PEND_HOLD;
      cmd.scan_op  = SCAN_HOLD;
      cmd.out_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.op)
               OP_ADD: begin
                  cmd.pend_op = PEND_CLR;
                  if (sts.count_zero) begin
                     state_in = ST_APPEND;
                  end else begin
                     cmd.scan_op = SCAN_CLR;
                     state_in    = ST_SRCH_RD;
                  end
               end
               OP_PATCH: begin
                  state_in = ST_PATCH;
               end
               OP_CLEAR: begin
                  cmd.cnt_op  = CNT_CLR;
                  cmd.pend_op = PEND_CLR;
                  state_in    = ST_FINISH;
               end
               OP_READ: begin
                  // read data lands in the datapath's read register by FINISH
                  cmd.rd_en  = sts.read_hit;
                  cmd.rd_sel = RD_ENTRY;
                  state_in   = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SCAN;
            state_in   = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (sts.key_match) begin
               // compaction starts at the matching slot
               state_in = ST_SHF_RD;
            end else if (sts.scan_last) begin
               if (sts.count_full) begin
                  cmd.scan_op = SCAN_CLR;
                  state_in    = ST_SHF_RD;
               end else begin
                  state_in = ST_APPEND;
               end
            end else begin
               cmd.scan_op = SCAN_INC;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SHF_RD: begin
            if (sts.scan_last) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = ST_APPEND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_SHF_WR;
            end
         end
         ST_SHF_WR: begin
            cmd.wr_sel  = WR_SHIFT;
            cmd.scan_op = SCAN_INC;
            state_in    = ST_SHF_RD;
         end
         ST_APPEND: begin
            cmd.wr_sel  = WR_APPEND;
            cmd.cnt_op  = CNT_INC;
            cmd.pend_op = PEND_APPEND;
            state_in    = ST_FINISH;
         end
         ST_PATCH: begin
            if (sts.patch_ok) begin
               cmd.wr_sel  = WR_PATCH;
               cmd.pend_op = PEND_CLR;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register must never be overwritten while a stalled response sits in it
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.rsp_busy)
      else $error("clm_ctrl: result loaded over a stalled response");

   // a shift write always follows a read of the next slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHF_WR) |-> ($past(state_ff) == ST_SHF_RD) && !sts.scan_last)
      else $error("clm_ctrl: shift write past the last held slot");

endmodule

`default_nettype wire

// ===== rtl/clm_dpath.sv =====
// ----------------------------------------------------------------------------
// clm_dpath: store, counters and result register of the call log table
// Entry store with one write and one registered read per cycle, the fill
// count, the scan pointer, the pending mark and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clm_dpath
   import clm_pkg::*;
#(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_sts_type             sts,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [KEY_W-1:0]  req_phone_key,
   input  wire logic [KIND_W-1:0] req_call_kind,
   input  wire logic [DUR_W-1:0]  req_duration_sec,
   input  wire logic [IDX_W-1:0]  req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_read_valid,
   output logic [KEY_W-1:0]       rsp_out_key,
   output logic [KIND_W-1:0]      rsp_out_kind,
   output logic [DUR_W-1:0]       rsp_out_duration,
   output logic [COUNT_W-1:0]     rsp_entry_count,
   output logic                   rsp_patch_done
);

   localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam int RW = (CW > IDX_W) ? CW : IDX_W;
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);

   logic [KEY_W-1:0]  key_mem [LOG_DEPTH];
   logic [KIND_W-1:0] kind_mem[LOG_DEPTH];
   logic [DUR_W-1:0]  dur_mem [LOG_DEPTH];

   op_type            req_op_ff;
   logic [KEY_W-1:0]  req_key_ff;
   logic [KIND_W-1:0] req_kind_ff;
   logic [DUR_W-1:0]  req_dur_ff;
   logic [IDX_W-1:0]  req_idx_ff;

   logic [KEY_W-1:0]  rd_key_ff;
   logic [KIND_W-1:0] rd_kind_ff;
   logic [DUR_W-1:0]  rd_dur_ff;

   logic [CW-1:0] count_ff;
   logic [AW-1:0] scan_ff;
   logic [AW-1:0] pend_slot_ff;
   logic          pend_valid_ff;
   logic          patch_hit_ff;

   logic                rsp_valid_ff;
   logic                rsp_read_valid_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [DUR_W-1:0]    rsp_dur_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_patch_ff;

   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              key_we;
   logic              meta_we;
   logic [KEY_W-1:0]  wr_key;
   logic [KIND_W-1:0] wr_kind;
   logic [DUR_W-1:0]  wr_dur;

   logic [CW-1:0] scan_next;
   logic [RW-1:0] idx_wide;
   logic [RW-1:0] count_rw;
   logic [RW-1:0] read_slot;
   logic [EW-1:0] count_wide;
   logic          read_hit;
   logic          is_read;

   assign scan_next  = CW'(scan_ff) + CW'(1);
   assign idx_wide   = RW'(req_idx_ff);
   assign count_rw   = RW'(count_ff);
   assign read_slot  = count_rw - RW'(1) - idx_wide;
   assign read_hit   = idx_wide < count_rw;
   assign count_wide = EW'(count_ff);
   assign is_read    = (req_op_ff == OP_READ);

   always_comb begin
      case (cmd.rd_sel)
         RD_SCAN:  rd_addr = scan_ff;
         RD_NEXT:  rd_addr = scan_next[AW-1:0];
         RD_ENTRY: rd_addr = read_slot[AW-1:0];
         default:  rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      key_we  = 1'b0;
      meta_we = 1'b0;
      wr_addr = scan_ff;
      wr_key  = rd_key_ff;
      wr_kind = rd_kind_ff;
      wr_dur  = rd_dur_ff;
      case (cmd.wr_sel)
         WR_NONE: begin
            key_we = 1'b0;
         end
         WR_SHIFT: begin
            key_we  = 1'b1;
            meta_we = 1'b1;
         end
         WR_APPEND: begin
            key_we  = 1'b1;
            meta_we = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_key  = req_key_ff;
            wr_kind = req_kind_ff;
            wr_dur  = req_dur_ff;
         end
         WR_PATCH: begin
            key_we  = 1'b1;
            wr_addr = pend_slot_ff;
            wr_key  = req_key_ff;
         end
         default: begin
            key_we = 1'b0;
         end
      endcase
   end

   // entry store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (meta_we) begin
         kind_mem[wr_addr] <= wr_kind;
         dur_mem[wr_addr]  <= wr_dur;
      end
      if (cmd.rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_kind_ff <= kind_mem[rd_addr];
         rd_dur_ff  <= dur_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_op_ff   <= op_type'(req_op);
         req_key_ff  <= req_phone_key;
         req_kind_ff <= req_call_kind;
         req_dur_ff  <= req_duration_sec;
         req_idx_ff  <= req_read_index;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.scan_op)
         SCAN_HOLD: scan_ff <= scan_ff;
         SCAN_CLR:  scan_ff <= '0;
         SCAN_INC:  scan_ff <= scan_next[AW-1:0];
         default:   scan_ff <= scan_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_slot_ff  <= '0;
         pend_valid_ff <= 1'b0;
         patch_hit_ff  <= 1'b0;
      end else begin
         case (cmd.cnt_op)
            CNT_HOLD: count_ff <= count_ff;
            CNT_CLR:  count_ff <= '0;
            CNT_INC:  count_ff <= count_ff + CW'(1);
            CNT_DEC:  count_ff <= count_ff - CW'(1);
            default:  count_ff <= count_ff;
         endcase
         case (cmd.pend_op)
            PEND_HOLD: pend_valid_ff <= pend_valid_ff;
            PEND_CLR:  pend_valid_ff <= 1'b0;
            PEND_APPEND: begin
               // unknown number: remember where it went for a later patch
               pend_valid_ff <= (req_key_ff == '0);
               pend_slot_ff  <= count_ff[AW-1:0];
            end
            default: pend_valid_ff <= pend_valid_ff;
         endcase
         if (cmd.load_req) begin
            patch_hit_ff <= 1'b0;
         end else if (cmd.wr_sel == WR_PATCH) begin
            patch_hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_read_valid_ff <= is_read && read_hit;
         rsp_key_ff        <= (is_read && read_hit) ? rd_key_ff : '0;
         rsp_kind_ff       <= (is_read && read_hit) ? rd_kind_ff : '0;
         rsp_dur_ff        <= (is_read && read_hit) ? rd_dur_ff : '0;
         rsp_count_ff      <= count_wide[COUNT_W-1:0];
         rsp_patch_ff      <= patch_hit_ff;
      end
   end

   assign sts.op         = req_op_ff;
   assign sts.key_match  = (rd_key_ff == req_key_ff);
   assign sts.scan_last  = (scan_next >= count_ff);
   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff >= DEPTH_C);
   assign sts.read_hit   = read_hit;
   assign sts.patch_ok   = pend_valid_ff && (CW'(pend_slot_ff) < count_ff) &&
                           (req_key_ff != '0);
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_valid   = rsp_read_valid_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_kind     = rsp_kind_ff;
   assign rsp_out_duration = rsp_dur_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_patch_done   = rsp_patch_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("clm_dpath: fill count above log depth");

   // the pending mark only ever points at a held entry
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (CW'(pend_slot_ff) < count_ff))
      else $error("clm_dpath: pending slot outside held entries");

   // an append never lands beyond the store
   assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_APPEND) |-> (count_ff < DEPTH_C))
      else $error("clm_dpath: append into a full log");

endmodule

`default_nettype wire

// ===== rtl/call_log_mru_table.sv =====
// ----------------------------------------------------------------------------
// call_log_mru_table: deduplicating most-recent-first call log
// Holds up to LOG_DEPTH entries (number, call kind, duration), oldest first
// in the store. Supports add, patch of a pending unknown number, clear, read.
//
// Request channel req_*: one request per handshake (valid high, stall low).
// The block takes one request at a time; req_stall stays high from the
// accept until the result has been moved into the response register.
// Response channel rsp_*: exactly one response per request, in order.
// Steps, accept to rsp_valid:
//   read, clear: dispatch, finish; patch: dispatch, patch, finish.
//   add: dispatch, a search reading and comparing held slots in turn, a
//   compaction for a repeated number or when a full log evicts its oldest
//   entry, append, finish; an add to an empty log skips the search.
//   Search and compaction share the store's one read and one write port.
// The next request is taken from the cycle its predecessor's response appears.
// A response stalled by rsp_stall holds in the response register; the next
// request is still accepted and worked on, and only its hand-off waits.
// Reset (synchronous) empties the log, drops the pending mark and the
// response; entry contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module call_log_mru_table
   import clm_pkg::*;
#(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [KEY_W-1:0]  req_phone_key,
   input  wire logic [KIND_W-1:0] req_call_kind,
   input  wire logic [DUR_W-1:0]  req_duration_sec,
   input  wire logic [IDX_W-1:0]  req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_read_valid,
   output logic [KEY_W-1:0]       rsp_out_key,
   output logic [KIND_W-1:0]      rsp_out_kind,
   output logic [DUR_W-1:0]       rsp_out_duration,
   output logic [COUNT_W-1:0]     rsp_entry_count,
   output logic                   rsp_patch_done
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   clm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   clm_dpath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_phone_key    (req_phone_key),
      .req_call_kind    (req_call_kind),
      .req_duration_sec (req_duration_sec),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_duration (rsp_out_duration),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_patch_done   (rsp_patch_done)
   );

endmodule

`default_nettype wire
